// File: rtl/core/bsr_unit_upper_trmv_macros.svh
// Assertion macros shared by the block's RTL.
`ifndef BSR_UNIT_UPPER_TRMV_MACROS_SVH
`define BSR_UNIT_UPPER_TRMV_MACROS_SVH

// Check cons in the same cycle as ante.
`define BSRUT_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define BSRUT_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/bsrut_pkg.sv
// Types and constants of the block-sparse upper triangular matrix-vector unit.
package bsrut_pkg;

  localparam int DATA_W     = 32;
  localparam int ACC_W      = 48;
  localparam int PROD_W     = 64;
  localparam int SUM_W      = 66;
  localparam int FRAC_W     = 16;
  localparam int IDX_W      = 6;
  localparam int OPC_W      = 3;
  localparam int COUNT_W    = 7;
  localparam int EDGE_W     = 4;
  localparam int SQ_W       = 2 * EDGE_W;
  localparam int DIV_W      = 7;
  localparam int GROW_W     = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD_X   = 3'd0,
    OP_LOAD_Y   = 3'd1,
    OP_ELEMENT  = 3'd2,
    OP_READ_ROW = 3'd3,
    OP_CLEAR    = 3'd4
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA_GAIN   = 3'd0,
    CFG_BETA_GAIN    = 3'd1,
    CFG_ROW_COUNT    = 3'd2,
    CFG_COLUMN_COUNT = 3'd3,
    CFG_BLOCK_EDGE   = 3'd4,
    CFG_COLUMN_MAJOR = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_ELEM_DIV,
    ST_ELEM_MAP,
    ST_ELEM_CHECK,
    ST_ELEM_READ,
    ST_ELEM_MUL,
    ST_READ_DIV,
    ST_READ_S,
    ST_READ_B,
    ST_READ_AH,
    ST_READ_AL,
    ST_READ_OUT
  } state_t;

  typedef struct packed {
    logic [OPC_W-1:0]         opcode;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         block_row;
    logic [IDX_W-1:0]         block_col;
    logic [IDX_W-1:0]         position;
    logic signed [DATA_W-1:0] data_value;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_index;
    logic signed [DATA_W-1:0] result_value;
    logic                     status;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [EDGE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quotient;
    logic [EDGE_W-1:0] remainder;
  } div_rsp_t;

endpackage

// File: rtl/core/bsrut_if.sv
// Valid/ready channel interfaces for items and results.
interface bsrut_item_if;
  logic               valid;
  logic               ready;
  bsrut_pkg::item_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bsrut_result_if;
  logic               valid;
  logic               ready;
  bsrut_pkg::result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/bsrut_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bsrut_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/bsrut_div.sv
// Restoring divider, one quotient bit per cycle, by the block edge.
module bsrut_div (
  input  logic                clk,
  input  logic                rst,
  input  bsrut_pkg::div_req_t req,
  output bsrut_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(bsrut_pkg::DIV_W + 1);

  logic [bsrut_pkg::DIV_W-1:0]  quo;
  logic [bsrut_pkg::EDGE_W-1:0] rem;
  logic [bsrut_pkg::EDGE_W-1:0] divisor;
  logic [CNT_W-1:0]             cnt;
  logic                         done;
  logic                         busy;
  logic [bsrut_pkg::EDGE_W:0]   trial;
  logic                         ge;
  logic [bsrut_pkg::EDGE_W:0]   diff;

  assign busy  = (cnt != '0);
  assign trial = {rem, quo[bsrut_pkg::DIV_W-1]};
  assign ge    = (trial >= {1'b0, divisor});
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (req.start) begin
      cnt  <= CNT_W'(bsrut_pkg::DIV_W);
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (busy) begin
        cnt <= CNT_W'(cnt - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      quo <= {quo[bsrut_pkg::DIV_W-2:0], ge};
      rem <= ge ? diff[bsrut_pkg::EDGE_W-1:0] : trial[bsrut_pkg::EDGE_W-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// File: rtl/core/bsrut_mul.sv
// Shared signed 32x32 multiplier with registered product.
module bsrut_mul (
  input  logic                                  clk,
  input  logic signed [bsrut_pkg::DATA_W-1:0]   a,
  input  logic signed [bsrut_pkg::DATA_W-1:0]   b,
  output logic signed [bsrut_pkg::PROD_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// File: rtl/core/bsr_unit_upper_trmv.sv
// Top level: y = beta*y + alpha*(x + U*x) over a BSR strict upper matrix, Q16.16.
// Loads are written straight from idle; an element and a read row each wait on
// the 7-step shared edge divider, then make up to three passes through the
// shared multiplier. Reset and a clear item run a pass zeroing the accumulators;
// no item is accepted meanwhile. Configuration resets to its documented values.
`include "bsr_unit_upper_trmv_macros.svh"

module bsr_unit_upper_trmv #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_EDGE = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [bsrut_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bsrut_pkg::CFG_DATA_W-1:0]    cfg_data,
  bsrut_item_if.sink                          items,
  bsrut_result_if.source                      results
);

  localparam int AW      = $clog2(MAX_ROWS);
  localparam int DATA_W  = bsrut_pkg::DATA_W;
  localparam int ACC_W   = bsrut_pkg::ACC_W;
  localparam int PROD_W  = bsrut_pkg::PROD_W;
  localparam int SUM_W   = bsrut_pkg::SUM_W;
  localparam int FRAC_W  = bsrut_pkg::FRAC_W;
  localparam int COUNT_W = bsrut_pkg::COUNT_W;
  localparam int EDGE_W  = bsrut_pkg::EDGE_W;
  localparam int SQ_W    = bsrut_pkg::SQ_W;
  localparam int DIV_W   = bsrut_pkg::DIV_W;
  localparam int GROW_W  = bsrut_pkg::GROW_W;

  function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W:0] v);
    if (v[ACC_W] != v[ACC_W-1]) begin
      return v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return v[ACC_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] sat_out(input logic [SUM_W-1:0] v);
    logic [SUM_W-DATA_W:0] hi;
    hi = v[SUM_W-1:DATA_W-1];
    if ((&hi) || !(|hi)) begin
      return v[DATA_W-1:0];
    end
    return v[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
  endfunction

  function automatic logic [SUM_W-1:0] ext_sum(input logic [PROD_W-1:0] v);
    return {{(SUM_W-PROD_W){v[PROD_W-1]}}, v};
  endfunction

  // configuration
  logic signed [DATA_W-1:0] alpha_gain;
  logic signed [DATA_W-1:0] beta_gain;
  logic [COUNT_W-1:0]       row_count;
  logic [COUNT_W-1:0]       column_count;
  logic [EDGE_W-1:0]        block_edge;
  logic                     column_major_blocks;

  logic [COUNT_W-1:0] rows;
  logic [COUNT_W-1:0] cols;
  logic [EDGE_W-1:0]  edge_len;
  logic [SQ_W-1:0]    edge_sq;
  logic [COUNT_W-1:0] rows_m1;
  logic [COUNT_W-1:0] cols_m1;
  logic [COUNT_W-1:0] dim_min;
  logic [COUNT_W-1:0] dim_diff;

  bsrut_pkg::state_t  state;
  bsrut_pkg::state_t  state_next;
  logic [AW-1:0]      sweep_cnt;

  bsrut_pkg::item_t   held_item;
  logic [GROW_W-1:0]  row_pos;
  logic [GROW_W-1:0]  col_pos;
  logic signed [ACC_W-1:0] s_acc;
  logic signed [SUM_W-1:0] total;
  logic               bad_dims;
  bsrut_pkg::result_t result_hold;
  logic               result_valid;

  logic               item_accept;
  logic               items_ready;
  logic               acc_we;
  logic               res_load;
  logic               x_we;
  logic               y_we;
  logic               load_ok;
  logic [GROW_W-1:0]  in_idx_g;
  logic [GROW_W-1:0]  idx_g;
  logic               is_read;

  logic [AW-1:0]      x_raddr;
  logic [AW-1:0]      acc_raddr;
  logic [AW-1:0]      acc_waddr;
  logic [ACC_W-1:0]   acc_wdata;
  logic [DATA_W-1:0]  x_rdata;
  logic [DATA_W-1:0]  y_rdata;
  logic [ACC_W-1:0]   acc_rdata;

  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;
  logic [ACC_W-1:0]         term;
  logic [ACC_W-1:0]         acc_new;
  logic [ACC_W:0]           s_sum;
  logic signed [DATA_W-1:0] s_hi;
  logic signed [DATA_W-1:0] s_lo;

  bsrut_pkg::div_req_t div_req;
  bsrut_pkg::div_rsp_t div_rsp;

  logic [EDGE_W-1:0]  local_r;
  logic [EDGE_W-1:0]  local_c;
  logic [GROW_W-1:0]  r_calc;
  logic [GROW_W-1:0]  c_calc;
  logic               pos_ok;
  logic               elem_hit;
  logic               idx_ok;
  logic               dims_ok;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_gain          <= 32'sh0001_0000;
      beta_gain           <= '0;
      row_count           <= COUNT_W'(64);
      column_count        <= COUNT_W'(64);
      block_edge          <= EDGE_W'(1);
      column_major_blocks <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        bsrut_pkg::CFG_ALPHA_GAIN:   alpha_gain <= cfg_data;
        bsrut_pkg::CFG_BETA_GAIN:    beta_gain <= cfg_data;
        bsrut_pkg::CFG_ROW_COUNT:    row_count <= cfg_data[COUNT_W-1:0];
        bsrut_pkg::CFG_COLUMN_COUNT: column_count <= cfg_data[COUNT_W-1:0];
        bsrut_pkg::CFG_BLOCK_EDGE:   block_edge <= cfg_data[EDGE_W-1:0];
        bsrut_pkg::CFG_COLUMN_MAJOR: column_major_blocks <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective dimensions
  always_comb begin
    if (row_count == '0) begin
      rows = COUNT_W'(1);
    end else if (row_count > MAX_ROWS) begin
      rows = COUNT_W'(MAX_ROWS);
    end else begin
      rows = row_count;
    end
    if (column_count == '0) begin
      cols = COUNT_W'(1);
    end else if (column_count > MAX_ROWS) begin
      cols = COUNT_W'(MAX_ROWS);
    end else begin
      cols = column_count;
    end
    if (block_edge == '0) begin
      edge_len = EDGE_W'(1);
    end else if (block_edge > MAX_EDGE) begin
      edge_len = EDGE_W'(MAX_EDGE);
    end else begin
      edge_len = block_edge;
    end
  end

  assign edge_sq  = SQ_W'(edge_len) * SQ_W'(edge_len);
  assign rows_m1  = COUNT_W'(rows - 1'b1);
  assign cols_m1  = COUNT_W'(cols - 1'b1);
  assign dim_min  = (rows_m1 < cols_m1) ? rows_m1 : cols_m1;
  assign dim_diff = (rows_m1 < cols_m1) ? COUNT_W'(cols_m1 - rows_m1)
                                        : COUNT_W'(rows_m1 - cols_m1);

  // item intake
  assign item_accept = items.valid && items_ready;
  assign items.ready = items_ready;
  assign in_idx_g    = GROW_W'(items.payload.row_index);
  assign load_ok     = (in_idx_g < MAX_ROWS);
  assign x_we = item_accept && (items.payload.opcode == bsrut_pkg::OP_LOAD_X) && load_ok;
  assign y_we = item_accept && (items.payload.opcode == bsrut_pkg::OP_LOAD_Y) && load_ok;

  assign div_req.start = item_accept &&
                         ((items.payload.opcode == bsrut_pkg::OP_ELEMENT) ||
                          (items.payload.opcode == bsrut_pkg::OP_READ_ROW));
  assign div_req.dividend = (items.payload.opcode == bsrut_pkg::OP_ELEMENT)
                            ? DIV_W'(items.payload.position) : dim_min;
  assign div_req.divisor  = edge_len;

  // element mapping and checks
  assign idx_g   = GROW_W'(held_item.row_index);
  assign is_read = (held_item.opcode == bsrut_pkg::OP_READ_ROW);
  assign local_r = column_major_blocks ? div_rsp.remainder : div_rsp.quotient[EDGE_W-1:0];
  assign local_c = column_major_blocks ? div_rsp.quotient[EDGE_W-1:0] : div_rsp.remainder;
  assign r_calc  = GROW_W'(held_item.block_row) * GROW_W'(edge_len) + GROW_W'(local_r);
  assign c_calc  = GROW_W'(held_item.block_col) * GROW_W'(edge_len) + GROW_W'(local_c);
  assign pos_ok  = (SQ_W'(held_item.position) < edge_sq);
  assign elem_hit = (row_pos < GROW_W'(rows)) && (col_pos < GROW_W'(cols)) &&
                    (col_pos > row_pos);
  assign idx_ok  = (idx_g < GROW_W'(rows));
  assign dims_ok = ((SQ_W'(dim_diff) + SQ_W'(div_rsp.remainder)) < SQ_W'(edge_len));

  // arithmetic around the shared multiplier
  assign prod_sh = prod >>> FRAC_W;
  assign term    = prod_sh[ACC_W-1:0];
  assign acc_new = sat_acc({acc_rdata[ACC_W-1], acc_rdata} + {term[ACC_W-1], term});
  assign s_sum   = {{(ACC_W+1-DATA_W){x_rdata[DATA_W-1]}}, x_rdata} +
                   {acc_rdata[ACC_W-1], acc_rdata};
  assign s_hi    = s_acc[ACC_W-1:FRAC_W];
  assign s_lo    = {{(DATA_W-FRAC_W){1'b0}}, s_acc[FRAC_W-1:0]};

  // store addressing
  assign x_raddr   = is_read ? idx_g[AW-1:0] : col_pos[AW-1:0];
  assign acc_raddr = is_read ? idx_g[AW-1:0] : row_pos[AW-1:0];
  assign acc_waddr = (state == bsrut_pkg::ST_SWEEP) ? sweep_cnt : row_pos[AW-1:0];
  assign acc_wdata = (state == bsrut_pkg::ST_SWEEP) ? '0 : acc_new;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bsrut_pkg::ST_SWEEP: begin
        if (sweep_cnt == AW'(MAX_ROWS - 1)) begin
          state_next = bsrut_pkg::ST_IDLE;
        end
      end
      bsrut_pkg::ST_IDLE: begin
        if (item_accept) begin
          case (items.payload.opcode)
            bsrut_pkg::OP_ELEMENT:  state_next = bsrut_pkg::ST_ELEM_DIV;
            bsrut_pkg::OP_READ_ROW: state_next = bsrut_pkg::ST_READ_DIV;
            bsrut_pkg::OP_CLEAR:    state_next = bsrut_pkg::ST_SWEEP;
            default:                state_next = bsrut_pkg::ST_IDLE;
          endcase
        end
      end
      bsrut_pkg::ST_ELEM_DIV: begin
        if (div_rsp.done) begin
          state_next = bsrut_pkg::ST_ELEM_MAP;
        end
      end
      bsrut_pkg::ST_ELEM_MAP: begin
        state_next = pos_ok ? bsrut_pkg::ST_ELEM_CHECK : bsrut_pkg::ST_IDLE;
      end
      bsrut_pkg::ST_ELEM_CHECK: begin
        state_next = elem_hit ? bsrut_pkg::ST_ELEM_READ : bsrut_pkg::ST_IDLE;
      end
      bsrut_pkg::ST_ELEM_READ: state_next = bsrut_pkg::ST_ELEM_MUL;
      bsrut_pkg::ST_ELEM_MUL:  state_next = bsrut_pkg::ST_IDLE;
      bsrut_pkg::ST_READ_DIV: begin
        if (div_rsp.done) begin
          if (!idx_ok) begin
            state_next = bsrut_pkg::ST_IDLE;
          end else if (!dims_ok) begin
            state_next = bsrut_pkg::ST_READ_OUT;
          end else begin
            state_next = bsrut_pkg::ST_READ_S;
          end
        end
      end
      bsrut_pkg::ST_READ_S:  state_next = bsrut_pkg::ST_READ_B;
      bsrut_pkg::ST_READ_B:  state_next = bsrut_pkg::ST_READ_AH;
      bsrut_pkg::ST_READ_AH: state_next = bsrut_pkg::ST_READ_AL;
      bsrut_pkg::ST_READ_AL: state_next = bsrut_pkg::ST_READ_OUT;
      bsrut_pkg::ST_READ_OUT: begin
        if (!result_valid || results.ready) begin
          state_next = bsrut_pkg::ST_IDLE;
        end
      end
      default: state_next = bsrut_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    items_ready = 1'b0;
    acc_we      = 1'b0;
    res_load    = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    case (state)
      bsrut_pkg::ST_IDLE:  items_ready = 1'b1;
      bsrut_pkg::ST_SWEEP: acc_we = 1'b1;
      bsrut_pkg::ST_ELEM_READ: begin
        mul_a = held_item.data_value;
        mul_b = x_rdata;
      end
      bsrut_pkg::ST_ELEM_MUL: acc_we = 1'b1;
      bsrut_pkg::ST_READ_S: begin
        mul_a = beta_gain;
        mul_b = y_rdata;
      end
      bsrut_pkg::ST_READ_B: begin
        mul_a = alpha_gain;
        mul_b = s_hi;
      end
      bsrut_pkg::ST_READ_AH: begin
        mul_a = alpha_gain;
        mul_b = s_lo;
      end
      bsrut_pkg::ST_READ_OUT: res_load = !result_valid || results.ready;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bsrut_pkg::ST_SWEEP;
      sweep_cnt    <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bsrut_pkg::ST_SWEEP) begin
        sweep_cnt <= AW'(sweep_cnt + 1'b1);
      end else begin
        sweep_cnt <= '0;
      end
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (results.ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (item_accept) begin
      held_item <= items.payload;
    end
    case (state)
      bsrut_pkg::ST_ELEM_MAP: begin
        row_pos <= r_calc;
        col_pos <= c_calc;
      end
      bsrut_pkg::ST_READ_DIV: begin
        bad_dims <= !dims_ok;
        total    <= '0;
      end
      bsrut_pkg::ST_READ_S:  s_acc <= sat_acc(s_sum);
      bsrut_pkg::ST_READ_B:  total <= ext_sum(prod_sh);
      bsrut_pkg::ST_READ_AH: total <= total + ext_sum(prod);
      bsrut_pkg::ST_READ_AL: total <= total + ext_sum(prod_sh);
      default: ;
    endcase
    if (res_load) begin
      result_hold.out_index    <= held_item.row_index;
      result_hold.result_value <= sat_out(total);
      result_hold.status       <= bad_dims;
    end
  end

  assign results.valid   = result_valid;
  assign results.payload = result_hold;

  bsrut_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  bsrut_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  bsrut_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_x_store (
    .clk   (clk),
    .we    (x_we),
    .waddr (in_idx_g[AW-1:0]),
    .wdata (items.payload.data_value),
    .raddr (x_raddr),
    .rdata (x_rdata)
  );

  bsrut_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_y_store (
    .clk   (clk),
    .we    (y_we),
    .waddr (in_idx_g[AW-1:0]),
    .wdata (items.payload.data_value),
    .raddr (idx_g[AW-1:0]),
    .rdata (y_rdata)
  );

  bsrut_ram #(.WIDTH(ACC_W), .DEPTH(MAX_ROWS)) u_acc_store (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  `BSRUT_ASSERT_SAME(a_div_done_waited, clk, rst, div_rsp.done, (state == bsrut_pkg::ST_ELEM_DIV) || (state == bsrut_pkg::ST_READ_DIV), "divider finished while sequencer was not waiting")
  `BSRUT_ASSERT_NEXT(a_clear_blocks, clk, rst, item_accept && (items.payload.opcode == bsrut_pkg::OP_CLEAR), !items.ready, "item taken right after a clear")
  `BSRUT_ASSERT_SAME(a_bad_dims_zero, clk, rst, (state == bsrut_pkg::ST_READ_OUT) && bad_dims, total == '0, "invalid-dimension result is not zero")
  `BSRUT_ASSERT_SAME(a_result_row_in_range, clk, rst, res_load, idx_g < GROW_W'(rows), "result for a row beyond the matrix")
  `BSRUT_ASSERT_SAME(a_acc_write_busy, clk, rst, acc_we, !items.ready, "accumulator written while taking items")

endmodule
